FILE: rtl/ckpb_pkg.sv
// ckpb_pkg: shared constants, register index codes and types for the
// color-keyed palette blitter. No dependencies.
`timescale 1ns / 1ps

package ckpb_pkg;

    // Address space and sprite size limits
    localparam int ADDR_BITS  = 20;
    localparam int MAX_DIM    = 1024;
    localparam int CNT_W      = $clog2(MAX_DIM);      // column/row counter width
    localparam int DIM_W      = 11;                   // width/height register width
    localparam int STRIDE_W   = 13;
    localparam int KEY_W      = 4;
    localparam int PIX_W      = 8;
    localparam int COLOR_W    = 8;
    localparam int PAL_W      = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;

    localparam logic [PIX_W-1:0] NIBBLE_MASK = 8'h0f;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS  = 4'd0,
        REG_LINE_STRIDE   = 4'd1,
        REG_SPRITE_WIDTH  = 4'd2,
        REG_SPRITE_HEIGHT = 4'd3,
        REG_COLOR_KEY     = 4'd4,
        REG_MIRROR        = 4'd5,
        REG_PALETTE_LOW   = 4'd6,
        REG_PALETTE_HIGH  = 4'd7
    } cfg_reg_t;

    // Configuration register file contents
    typedef struct packed {
        logic [ADDR_BITS-1:0] base_address;
        logic [STRIDE_W-1:0]  line_stride;
        logic [DIM_W-1:0]     sprite_width;
        logic [DIM_W-1:0]     sprite_height;
        logic [KEY_W-1:0]     color_key;
        logic                 mirror;
        logic [PAL_W-1:0]     palette_low;
        logic [PAL_W-1:0]     palette_high;
    } cfg_t;

    // Address generator result for the pixel being issued
    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic                 last;
        logic                 at_start;
    } addr_res_t;

    // Zero acts as one, oversize acts as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        begin
            if (d == '0)
                r = DIM_W'(1);
            else if (d > DIM_W'(MAX_DIM))
                r = DIM_W'(MAX_DIM);
            else
                r = d;
            return r;
        end
    endfunction

endpackage

FILE: rtl/ckpb_pix_if.sv
// ckpb_pix_if: source pixel index channel (valid/ready).
// Depends on ckpb_pkg.
`timescale 1ns / 1ps

interface ckpb_pix_if;
    logic                      valid;
    logic                      ready;
    logic [ckpb_pkg::PIX_W-1:0] pixel_index;

    modport source (output valid, output pixel_index, input ready);
    modport sink   (input valid, input pixel_index, output ready);
endinterface

FILE: rtl/ckpb_wr_if.sv
// ckpb_wr_if: framebuffer write channel (valid/ready).
// Depends on ckpb_pkg.
`timescale 1ns / 1ps

interface ckpb_wr_if;
    logic                          valid;
    logic                          ready;
    logic                          write_enable;
    logic [ckpb_pkg::ADDR_BITS-1:0] write_address;
    logic [ckpb_pkg::COLOR_W-1:0]   write_data;
    logic                          last_pixel;

    modport source (output valid, output write_enable, output write_address,
                    output write_data, output last_pixel, input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input write_data, input last_pixel, output ready);
endinterface

FILE: rtl/ckpb_cfg_regs.sv
// ckpb_cfg_regs: configuration register file behind the plain write port.
// Depends on ckpb_pkg.
`timescale 1ns / 1ps

module ckpb_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ckpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ckpb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output ckpb_pkg::cfg_t                      cfg
);

    ckpb_pkg::cfg_t cfg_reg;
    ckpb_pkg::cfg_t cfg_next;

    // Decode the write; bits above a register's width are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (ckpb_pkg::cfg_reg_t'(cfg_index))
                ckpb_pkg::REG_BASE_ADDRESS:
                    cfg_next.base_address = cfg_wdata[ckpb_pkg::ADDR_BITS-1:0];
                ckpb_pkg::REG_LINE_STRIDE:
                    cfg_next.line_stride = cfg_wdata[ckpb_pkg::STRIDE_W-1:0];
                ckpb_pkg::REG_SPRITE_WIDTH:
                    cfg_next.sprite_width = cfg_wdata[ckpb_pkg::DIM_W-1:0];
                ckpb_pkg::REG_SPRITE_HEIGHT:
                    cfg_next.sprite_height = cfg_wdata[ckpb_pkg::DIM_W-1:0];
                ckpb_pkg::REG_COLOR_KEY:
                    cfg_next.color_key = cfg_wdata[ckpb_pkg::KEY_W-1:0];
                ckpb_pkg::REG_MIRROR:
                    cfg_next.mirror = cfg_wdata[0];
                ckpb_pkg::REG_PALETTE_LOW:
                    cfg_next.palette_low = cfg_wdata[ckpb_pkg::PAL_W-1:0];
                ckpb_pkg::REG_PALETTE_HIGH:
                    cfg_next.palette_high = cfg_wdata[ckpb_pkg::PAL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address  <= '0;
            cfg_reg.line_stride   <= ckpb_pkg::STRIDE_W'(320);
            cfg_reg.sprite_width  <= ckpb_pkg::DIM_W'(1);
            cfg_reg.sprite_height <= ckpb_pkg::DIM_W'(1);
            cfg_reg.color_key     <= '0;
            cfg_reg.mirror        <= 1'b0;
            cfg_reg.palette_low   <= '0;
            cfg_reg.palette_high  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ckpb_addr_gen.sv
// ckpb_addr_gen: column/row counters and running row base that produce the
// framebuffer address and the last-pixel flag. Depends on ckpb_pkg.
`timescale 1ns / 1ps

module ckpb_addr_gen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ckpb_pkg::cfg_t       cfg,
    input  logic                 advance,
    output ckpb_pkg::addr_res_t  res
);

    logic [ckpb_pkg::CNT_W-1:0]     col_reg, col_next;
    logic [ckpb_pkg::CNT_W-1:0]     row_reg, row_next;
    logic [ckpb_pkg::ADDR_BITS-1:0] row_base_reg, row_base_next;

    logic [ckpb_pkg::DIM_W-1:0]     w;
    logic [ckpb_pkg::DIM_W-1:0]     h;
    logic                           at_start;
    logic [ckpb_pkg::ADDR_BITS-1:0] cur_base;
    logic [ckpb_pkg::ADDR_BITS-1:0] col_addr;
    logic                           row_end;
    logic                           sprite_end;

    // Effective dimensions and current row start
    always_comb
    begin
        w        = ckpb_pkg::clamp_dim(cfg.sprite_width);
        h        = ckpb_pkg::clamp_dim(cfg.sprite_height);
        at_start = (col_reg == '0) && (row_reg == '0);
        cur_base = at_start ? cfg.base_address : row_base_reg;
    end

    // Column offset, mirrored when requested (wraps modulo the address space)
    always_comb
    begin
        if (cfg.mirror)
            col_addr = ckpb_pkg::ADDR_BITS'(w) - ckpb_pkg::ADDR_BITS'(1)
                       - ckpb_pkg::ADDR_BITS'(col_reg);
        else
            col_addr = ckpb_pkg::ADDR_BITS'(col_reg);
    end

    // End of row / end of sprite; >= also covers a size shrunk mid-sprite
    always_comb
    begin
        row_end    = (ckpb_pkg::DIM_W'(col_reg) + ckpb_pkg::DIM_W'(1)) >= w;
        sprite_end = row_end &&
                     ((ckpb_pkg::DIM_W'(row_reg) + ckpb_pkg::DIM_W'(1)) >= h);
    end

    // Counter and row base update per issued pixel
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (advance)
        begin
            if (sprite_end)
            begin
                col_next      = '0;
                row_next      = '0;
                row_base_next = cfg.base_address;
            end
            else if (row_end)
            begin
                col_next      = '0;
                row_next      = row_reg + ckpb_pkg::CNT_W'(1);
                row_base_next = cur_base + ckpb_pkg::ADDR_BITS'(cfg.line_stride);
            end
            else
            begin
                col_next      = col_reg + ckpb_pkg::CNT_W'(1);
                row_base_next = cur_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

    assign res.address  = cur_base + col_addr;
    assign res.last     = sprite_end;
    assign res.at_start = at_start;

endmodule

FILE: rtl/ckpb_color_map.sv
// ckpb_color_map: palette lookup and color-key test for one pixel index.
// Depends on ckpb_pkg.
`timescale 1ns / 1ps

module ckpb_color_map (
    input  ckpb_pkg::cfg_t               cfg,
    input  logic [ckpb_pkg::PIX_W-1:0]   pixel_index,
    output logic                         write_enable,
    output logic [ckpb_pkg::COLOR_W-1:0] write_data
);

    logic [2*ckpb_pkg::PAL_W-1:0] palette;
    logic [ckpb_pkg::KEY_W-1:0]   nibble;

    // 16 bytes, entry 0 in the lowest byte
    always_comb
    begin
        palette = {cfg.palette_high, cfg.palette_low};
        nibble  = ckpb_pkg::KEY_W'(pixel_index & ckpb_pkg::NIBBLE_MASK);
    end

    assign write_data   = palette[nibble * ckpb_pkg::COLOR_W +: ckpb_pkg::COLOR_W];
    // Key compares against the full index, so only indexes 0..15 can match
    assign write_enable = (pixel_index != ckpb_pkg::PIX_W'(cfg.color_key));

endmodule

FILE: rtl/color_keyed_palette_blit.sv
// color_keyed_palette_blit: sprite blitter top level.
// An accepted pixel beat passes the input register, then the result register, to its write beat on fb_write.
// Throughput: one pixel per clock while fb_write is ready, set by the input register -> result register path.
// A stalled output holds its beat while one more pixel waits in the input register.
// Reset (rst_n, async, active low) clears counters, valid bits and config registers to
// their reset values (data registers are not); the block accepts pixels right after reset.
`timescale 1ns / 1ps

module color_keyed_palette_blit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ckpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ckpb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    ckpb_pix_if.sink                        pixel_in,
    ckpb_wr_if.source                       fb_write
);

    ckpb_pkg::cfg_t      cfg;
    ckpb_pkg::addr_res_t addr_res;

    // Input stage
    logic                         in_valid_reg, in_valid_next;
    logic [ckpb_pkg::PIX_W-1:0]   pixel_reg, pixel_next;

    // Result stage
    logic                           out_valid_reg, out_valid_next;
    logic                           we_reg, we_next;
    logic [ckpb_pkg::ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ckpb_pkg::COLOR_W-1:0]   data_reg, data_next;
    logic                           last_reg, last_next;

    logic                         res_take;
    logic                         res_load;
    logic                         in_accept;
    logic                         map_we;
    logic [ckpb_pkg::COLOR_W-1:0] map_data;

    ckpb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ckpb_addr_gen u_addr_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (res_load),
        .res     (addr_res)
    );

    ckpb_color_map u_color_map (
        .cfg          (cfg),
        .pixel_index  (pixel_reg),
        .write_enable (map_we),
        .write_data   (map_data)
    );

    // Pipeline handshake: result stage frees when empty or its beat is taken
    assign res_take       = !out_valid_reg || fb_write.ready;
    assign res_load       = in_valid_reg && res_take;
    assign pixel_in.ready = !in_valid_reg || res_take;
    assign in_accept      = pixel_in.valid && pixel_in.ready;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        pixel_next    = pixel_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
            pixel_next    = pixel_in.pixel_index;
        end
        else if (res_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        we_next        = we_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            we_next        = map_we;
            addr_next      = addr_res.address;
            data_next      = map_data;
            last_next      = addr_res.last;
        end
        else if (fb_write.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
        we_reg    <= we_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        last_reg  <= last_next;
    end

    assign fb_write.valid         = out_valid_reg;
    assign fb_write.write_enable  = we_reg;
    assign fb_write.write_address = addr_reg;
    assign fb_write.write_data    = data_reg;
    assign fb_write.last_pixel    = last_reg;

    // A pixel moving into the result stage always shows up as a valid beat
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid_reg)
        else $error("result stage lost a pixel");

    // After the last pixel the counters are back at the sprite start
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && addr_res.last) |=> addr_res.at_start)
        else $error("counters not rewound after last pixel");

    // A keyed pixel is issued with its write suppressed
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (pixel_reg == ckpb_pkg::PIX_W'(cfg.color_key))) |=> !we_reg)
        else $error("color-keyed pixel issued as a write");

endmodule
